### design/dots_pkg.sv
// Shared types and codes of the deadline-ordered timer scheduler.
`default_nettype none
package dots_pkg;
	localparam int TIME_W = 48;
	localparam int DIV_STEPS = 48;
	localparam logic [TIME_W-1:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [4:0] RESULT_CAP = 5'd16;

	localparam logic [1:0] ACT_ADVANCE  = 2'd0;
	localparam logic [1:0] ACT_ONESHOT  = 2'd1;
	localparam logic [1:0] ACT_PERIODIC = 2'd2;
	localparam logic [1:0] ACT_CANCEL   = 2'd3;

	localparam logic [2:0] KIND_FIRED   = 3'd0;
	localparam logic [2:0] KIND_ARMED   = 3'd1;
	localparam logic [2:0] KIND_FULL    = 3'd2;
	localparam logic [2:0] KIND_NOTHING = 3'd3;
	localparam logic [2:0] KIND_CANCEL  = 3'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  client_id;
		logic [31:0] delay;
		logic [31:0] period;
		logic [31:0] time_step;
	} item_t;

	typedef struct packed {
		logic  vld;
		item_t item;
	} head_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [7:0]        fired_id;
		logic [TIME_W-1:0] elapsed;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [7:0]        client;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] reference;
		logic [31:0]       period;
	} slot_t;
endpackage
`default_nettype wire

### design/dots_front.sv
// Front end: accepts items into a two-entry queue ahead of the sequencer.
`default_nettype none
module dots_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire dots_pkg::item_t in_item,
	input  wire logic           pop,
	output logic                busy,
	output dots_pkg::head_t     head
);
	import dots_pkg::*;

	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign head = '{(cnt_q != 2'd0), buf_q[rd_q]};

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

### design/dots_rem.sv
// Bit-serial remainder unit: 48-bit dividend modulo 32-bit divisor.
`default_nettype none
module dots_rem (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [47:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      rem
);
	import dots_pkg::*;

	logic [47:0] num_q;
	logic [31:0] div_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] nxt;

	assign trial = {rem_q, num_q[47]};
	assign nxt = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
	assign done = done_q;
	assign rem = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			num_q <= '0;
			div_q <= '0;
			rem_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= dividend;
				div_q <= divisor;
				rem_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= nxt[31:0];
				num_q <= {num_q[46:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### design/dots_back.sv
// Back end: slot table, scan sequencer and firing logic.
`default_nettype none
module dots_back #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dots_pkg::head_t head,
	output logic                 pop,
	input  wire logic [4:0]      quota,
	output dots_pkg::result_t    res,
	output logic                 res_stb
);
	import dots_pkg::*;

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE, S_ARM, S_CANCEL, S_SCAN, S_FIRE, S_DIV, S_RESCH, S_NEXT
	} state_t;

	state_t             state_q;
	item_t              item_q;
	logic [TIME_W-1:0]  ct_q;
	logic [4:0]         limit_q;
	logic [4:0]         nfire_q;
	logic [TIMER_SLOTS-1:0] done_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [CW-1:0]      scan_q;
	logic               rd_vld_s1;
	logic [IW-1:0]      rd_idx_s1;
	slot_t              rdata_s1;
	logic               best_found_q;
	logic [IW-1:0]      best_idx_q;
	slot_t              best_q;
	logic               pend_vld_q;
	result_t            pend_q;
	result_t            res_q;
	logic               stb_q;

	slot_t              mem [TIMER_SLOTS];
	logic               mem_we;
	logic [IW-1:0]      mem_wa;
	slot_t              mem_wd;
	logic [IW-1:0]      rd_addr;

	logic               scanning;
	logic               issue;
	logic               scan_end;
	logic               cand;
	logic               better;
	logic               arm_free;
	logic [31:0]        first;
	logic [48:0]        arm_sum;
	logic [48:0]        step_sum;
	logic [48:0]        resch_sum;
	logic [TIME_W-1:0]  arm_dl;
	logic [TIME_W-1:0]  new_dl;
	logic               div_start;
	logic               div_done;
	logic [31:0]        div_rem;

	assign scanning = (state_q == S_CANCEL) || (state_q == S_SCAN);
	assign issue = scanning && (scan_q != SLOTS_C);
	assign scan_end = scanning && (scan_q == SLOTS_C) && !rd_vld_s1;
	assign rd_addr = scan_q[IW-1:0];
	assign pop = (state_q == S_IDLE) && head.vld;

	assign cand = valid_q[rd_idx_s1] && !done_q[rd_idx_s1] && (rdata_s1.deadline <= ct_q);
	assign better = !best_found_q || (rdata_s1.deadline < best_q.deadline);
	assign arm_free = (scan_q != SLOTS_C) && !valid_q[scan_q[IW-1:0]];

	assign first = (item_q.action == ACT_PERIODIC && item_q.delay == 32'd0) ?
		item_q.period : item_q.delay;
	assign arm_sum = {1'b0, ct_q} + {17'd0, first};
	assign arm_dl = arm_sum[48] ? TIME_MAX : arm_sum[TIME_W-1:0];
	assign step_sum = {1'b0, ct_q} + {17'd0, head.item.time_step};
	// next deadline past now: now - ((now - deadline) mod period) + period
	assign resch_sum = {1'b0, ct_q - {16'd0, div_rem}} + {17'd0, best_q.period};
	assign new_dl = resch_sum[48] ? TIME_MAX : resch_sum[TIME_W-1:0];

	assign div_start = (state_q == S_FIRE) && (best_q.period != 32'd0);

	dots_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ct_q - best_q.deadline),
		.divisor  (best_q.period),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = best_idx_q;
		mem_wd = best_q;
		if (state_q == S_ARM && arm_free) begin
			mem_we = 1'b1;
			mem_wa = scan_q[IW-1:0];
			mem_wd.client = item_q.client_id;
			mem_wd.deadline = arm_dl;
			mem_wd.reference = ct_q;
			mem_wd.period = (item_q.action == ACT_PERIODIC) ? item_q.period : 32'd0;
		end else if (state_q == S_RESCH) begin
			mem_we = 1'b1;
			mem_wd.deadline = new_dl;
			mem_wd.reference = ct_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_s1 <= mem[rd_addr];
	end

	assign res = res_q;
	assign res_stb = stb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			item_q <= '0;
			ct_q <= '0;
			limit_q <= '0;
			nfire_q <= '0;
			done_q <= '0;
			valid_q <= '0;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			best_found_q <= 1'b0;
			best_idx_q <= '0;
			best_q <= '0;
			pend_vld_q <= 1'b0;
			pend_q <= '0;
			res_q <= '0;
			stb_q <= 1'b0;
		end else begin
			stb_q <= 1'b0;
			rd_vld_s1 <= issue;
			rd_idx_s1 <= rd_addr;
			if (issue) scan_q <= scan_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (head.vld) begin
						item_q <= head.item;
						scan_q <= '0;
						best_found_q <= 1'b0;
						case (head.item.action)
							ACT_ADVANCE: begin
								ct_q <= step_sum[48] ? TIME_MAX : step_sum[TIME_W-1:0];
								limit_q <= (quota == 5'd0 || quota > RESULT_CAP) ?
									RESULT_CAP : quota;
								nfire_q <= '0;
								done_q <= '0;
								pend_vld_q <= 1'b0;
								state_q <= S_SCAN;
							end
							ACT_CANCEL: state_q <= S_CANCEL;
							default: state_q <= S_ARM;
						endcase
					end
				end
				S_ARM: begin
					if (scan_q == SLOTS_C) begin
						res_q <= '{KIND_FULL, item_q.client_id, '0, 1'b1};
						stb_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (arm_free) begin
						valid_q[scan_q[IW-1:0]] <= 1'b1;
						res_q <= '{KIND_ARMED, item_q.client_id, '0, 1'b1};
						stb_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_CANCEL: begin
					if (rd_vld_s1 && valid_q[rd_idx_s1] &&
						rdata_s1.client == item_q.client_id) begin
						valid_q[rd_idx_s1] <= 1'b0;
					end
					if (scan_end) begin
						res_q <= '{KIND_CANCEL, item_q.client_id, '0, 1'b1};
						stb_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (rd_vld_s1 && cand && better) begin
						best_found_q <= 1'b1;
						best_idx_q <= rd_idx_s1;
						best_q <= rdata_s1;
					end
					if (scan_end) begin
						if (best_found_q) begin
							state_q <= S_FIRE;
						end else begin
							// close out the item: held firing or nothing due
							if (pend_vld_q) res_q <= '{pend_q.kind, pend_q.fired_id,
								pend_q.elapsed, 1'b1};
							else res_q <= '{KIND_NOTHING, 8'd0, '0, 1'b1};
							stb_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_FIRE: begin
					if (pend_vld_q) begin
						res_q <= pend_q;
						stb_q <= 1'b1;
					end
					pend_q <= '{KIND_FIRED, best_q.client, ct_q - best_q.reference, 1'b0};
					pend_vld_q <= 1'b1;
					done_q[best_idx_q] <= 1'b1;
					nfire_q <= nfire_q + 5'd1;
					if (best_q.period == 32'd0) begin
						valid_q[best_idx_q] <= 1'b0;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_RESCH;
				end
				S_RESCH: state_q <= S_NEXT;
				S_NEXT: begin
					if (nfire_q == limit_q) begin
						res_q <= '{pend_q.kind, pend_q.fired_id, pend_q.elapsed, 1'b1};
						stb_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						scan_q <= '0;
						best_found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/deadline_ordered_timer_scheduler.sv
// Top level of the deadline-ordered timer scheduler.
// Items enter a two-entry queue; busy is high only while that queue is full.
// Each item is first taken from the queue. An arm item then searches for the
// lowest free slot, a cancel item makes one table read per slot. An advance
// item runs one full table scan per firing, plus a final scan that finds
// nothing unless the quota ends the item first; a fired one-shot timer is
// retired, and a periodic one is rescheduled with the 48-step bit-serial
// remainder unit.
// Results appear for exactly one cycle on strobe and cannot be held off; last
// marks the final result of each item.
`default_nettype none
module deadline_ordered_timer_scheduler #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  client_id,
	input  wire logic [31:0] delay,
	input  wire logic [31:0] period,
	input  wire logic [31:0] time_step,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_data,
	output logic             strobe,
	output logic [2:0]       kind,
	output logic [7:0]       fired_id,
	output logic [47:0]      elapsed,
	output logic             last
);
	import dots_pkg::*;

	item_t   in_item;
	head_t   head;
	logic    pop;
	logic [4:0] quota_q;
	result_t res;

	assign in_item = '{action, client_id, delay, period, time_step};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) quota_q <= '0;
		else if (cfg_we) quota_q <= cfg_data;
	end

	dots_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.in_item (in_item),
		.pop     (pop),
		.busy    (busy),
		.head    (head)
	);

	dots_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.quota   (quota_q),
		.res     (res),
		.res_stb (strobe)
	);

	assign kind = res.kind;
	assign fired_id = res.fired_id;
	assign elapsed = res.elapsed;
	assign last = res.last;

	a_nothing_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_NOTHING |-> last && fired_id == 8'd0)
		else $error("nothing-due result not final");
	a_elapsed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind != KIND_FIRED |-> elapsed == '0)
		else $error("elapsed set on non-firing result");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_ARMED || kind == KIND_FULL || kind == KIND_CANCEL) |-> last)
		else $error("control result not final");
endmodule
`default_nettype wire
